// File: hw/rtl/rmv_pkg.sv
// ----------------------------------------------------------------------------
// rmv_pkg
// Shared widths and controller/datapath interface types for the running
// statistics block.
// ----------------------------------------------------------------------------
`default_nettype none

package rmv_pkg;

   localparam int SAMPLE_WIDTH = 16;
   localparam int FRAC_BITS    = 8;
   localparam int COUNT_WIDTH  = 32;
   localparam int SUM_WIDTH    = 48;
   localparam int SQ_WIDTH     = 64;
   localparam int PROD_WIDTH   = SQ_WIDTH + COUNT_WIDTH;
   localparam int DVD_WIDTH    = PROD_WIDTH + FRAC_BITS;
   localparam int DVR_WIDTH    = 2 * COUNT_WIDTH;
   localparam int QUO_WIDTH    = 64;
   localparam int MEAN_WIDTH   = 24;
   localparam int VAR_WIDTH    = 39;
   localparam int STEP_WIDTH   = 7;

   // iteration counts of the serial units
   localparam int MUL_STEPS  = SUM_WIDTH;
   localparam int MEAN_STEPS = SUM_WIDTH + FRAC_BITS;
   localparam int VAR_STEPS  = DVD_WIDTH;

   typedef struct packed {
      logic update;
      logic mul_load;
      logic mul_step;
      logic divm_load;
      logic div_step;
      logic mean_take;
      logic divv_load;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

// File: hw/rtl/rmv_ctrl.sv
// ----------------------------------------------------------------------------
// rmv_ctrl
// Sequencer: update, serial multiplies, mean divide, variance divide, output.
// ----------------------------------------------------------------------------
`default_nettype none

module rmv_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_tvalid,
   output logic                 req_tready,
   input  rmv_pkg::status_type  status,
   output rmv_pkg::cmd_type     cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SETUP = 3'd1;
   localparam logic [2:0] ST_MUL   = 3'd2;
   localparam logic [2:0] ST_DIVM  = 3'd3;
   localparam logic [2:0] ST_MTAKE = 3'd4;
   localparam logic [2:0] ST_DIVV  = 3'd5;
   localparam logic [2:0] ST_DONE  = 3'd6;

   localparam logic [rmv_pkg::STEP_WIDTH-1:0] MUL_LAST  =
      rmv_pkg::STEP_WIDTH'(rmv_pkg::MUL_STEPS - 1);
   localparam logic [rmv_pkg::STEP_WIDTH-1:0] MEAN_LAST =
      rmv_pkg::STEP_WIDTH'(rmv_pkg::MEAN_STEPS - 1);
   localparam logic [rmv_pkg::STEP_WIDTH-1:0] VAR_LAST  =
      rmv_pkg::STEP_WIDTH'(rmv_pkg::VAR_STEPS - 1);

   logic [2:0]                      state_ff, state_in;
   logic [rmv_pkg::STEP_WIDTH-1:0]  step_ff, step_in;

   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff + 1'b1;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.update = 1'b1;
               state_in   = ST_SETUP;
            end
         end
         ST_SETUP: begin
            cmd.mul_load = 1'b1;
            step_in      = '0;
            state_in     = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul_step = 1'b1;
            if (step_ff == MUL_LAST) begin
               cmd.divm_load = 1'b1;
               step_in       = '0;
               state_in      = ST_DIVM;
            end
         end
         ST_DIVM: begin
            cmd.div_step = 1'b1;
            if (step_ff == MEAN_LAST) begin
               state_in = ST_MTAKE;
            end
         end
         ST_MTAKE: begin
            cmd.mean_take = 1'b1;
            cmd.divv_load = 1'b1;
            step_in       = '0;
            state_in      = ST_DIVV;
         end
         ST_DIVV: begin
            cmd.div_step = 1'b1;
            if (step_ff == VAR_LAST) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/rmv_dp.sv
// ----------------------------------------------------------------------------
// rmv_dp
// Datapath: running sums, min/max, shift-add multipliers, restoring divider
// and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rmv_dp (
   input  wire                   clock,
   input  wire                   reset,
   input  rmv_pkg::cmd_type      cmd,
   output rmv_pkg::status_type   status,
   input  wire  [15:0]           req_tdata,
   output logic                  rsp_tvalid,
   input  wire                   rsp_tready,
   output logic [127:0]          rsp_tdata,
   output logic [1:0]            rsp_tuser
);

   localparam int SW = rmv_pkg::SAMPLE_WIDTH;
   localparam int CW = rmv_pkg::COUNT_WIDTH;
   localparam int UW = rmv_pkg::SUM_WIDTH;
   localparam int QW = rmv_pkg::SQ_WIDTH;
   localparam int PW = rmv_pkg::PROD_WIDTH;
   localparam int DW = rmv_pkg::DVD_WIDTH;
   localparam int RW = rmv_pkg::DVR_WIDTH;
   localparam int OW = rmv_pkg::QUO_WIDTH;
   localparam int MW = rmv_pkg::MEAN_WIDTH;
   localparam int VW = rmv_pkg::VAR_WIDTH;
   localparam int FB = rmv_pkg::FRAC_BITS;

   // statistics state
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [UW-1:0]        sum_ff, sum_in;
   logic [QW-1:0]        sq_ff, sq_in;
   logic signed [SW-1:0] min_ff, min_in, max_ff, max_in;
   logic                 sat_ff, sat_in;

   logic signed [SW-1:0] smp;
   logic [SW:0]          smp_abs;
   logic [2*SW+1:0]      smp_sqr;
   logic                 full;

   always_comb begin
      smp     = signed'(req_tdata[SW-1:0]);
      smp_abs = smp[SW-1] ? (SW+1)'(-{smp[SW-1], smp}) : {1'b0, smp};
      smp_sqr = smp_abs * smp_abs;
      full    = (cnt_ff == {CW{1'b1}});
      cnt_in  = cnt_ff;
      sum_in  = sum_ff;
      sq_in   = sq_ff;
      min_in  = min_ff;
      max_in  = max_ff;
      sat_in  = sat_ff;
      if (cmd.update) begin
         sat_in = full;
         if (!full) begin
            cnt_in = cnt_ff + 1'b1;
            sum_in = sum_ff + UW'(smp);
            sq_in  = sq_ff + QW'(smp_sqr);
            if (cnt_ff == '0 || smp < min_ff) min_in = smp;
            if (cnt_ff == '0 || smp > max_ff) max_in = smp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         sum_ff <= '0;
         sq_ff  <= '0;
         min_ff <= '0;
         max_ff <= '0;
         sat_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         sum_ff <= sum_in;
         sq_ff  <= sq_in;
         min_ff <= min_in;
         max_ff <= max_in;
         sat_ff <= sat_in;
      end
   end

   // magnitude of the sum
   logic          neg;
   logic [UW-1:0] mag;
   assign neg = sum_ff[UW-1];
   assign mag = neg ? (~sum_ff + 1'b1) : sum_ff;

   // shift-add multipliers: n*sumsq and mag*mag; divisor n*(n-1)
   logic [PW-1:0] ma_cand_ff, ma_cand_in, ma_acc_ff, ma_acc_in;
   logic [CW-1:0] ma_plr_ff, ma_plr_in;
   logic [PW-1:0] mb_cand_ff, mb_cand_in, mb_acc_ff, mb_acc_in;
   logic [UW-1:0] mb_plr_ff, mb_plr_in;
   logic [RW-1:0] dvr_ff, dvr_in;

   always_comb begin
      ma_cand_in = ma_cand_ff;
      ma_plr_in  = ma_plr_ff;
      ma_acc_in  = ma_acc_ff;
      mb_cand_in = mb_cand_ff;
      mb_plr_in  = mb_plr_ff;
      mb_acc_in  = mb_acc_ff;
      dvr_in     = dvr_ff;
      if (cmd.mul_load) begin
         ma_cand_in = PW'(sq_ff);
         ma_plr_in  = cnt_ff;
         ma_acc_in  = '0;
         mb_cand_in = PW'(mag);
         mb_plr_in  = mag;
         mb_acc_in  = '0;
         dvr_in     = cnt_ff * (cnt_ff - 1'b1);
      end else if (cmd.mul_step) begin
         if (ma_plr_ff[0]) ma_acc_in = ma_acc_ff + ma_cand_ff;
         if (mb_plr_ff[0]) mb_acc_in = mb_acc_ff + mb_cand_ff;
         ma_cand_in = {ma_cand_ff[PW-2:0], 1'b0};
         mb_cand_in = {mb_cand_ff[PW-2:0], 1'b0};
         ma_plr_in  = {1'b0, ma_plr_ff[CW-1:1]};
         mb_plr_in  = {1'b0, mb_plr_ff[UW-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      ma_cand_ff <= ma_cand_in;
      ma_plr_ff  <= ma_plr_in;
      ma_acc_ff  <= ma_acc_in;
      mb_cand_ff <= mb_cand_in;
      mb_plr_ff  <= mb_plr_in;
      mb_acc_ff  <= mb_acc_in;
      dvr_ff     <= dvr_in;
   end

   // restoring divider, one quotient bit a cycle, dividend left-aligned
   logic [DW-1:0] dsh_ff, dsh_in;
   logic [RW-1:0] rem_ff, rem_in;
   logic [RW-1:0] dsor_ff, dsor_in;
   logic [OW-1:0] quo_ff, quo_in;
   logic [RW:0]   trial;
   logic          fits;
   logic [MW-1:0] mean_ff, mean_in, qm;
   logic          vok_ff, vok_in;

   always_comb begin
      trial   = {rem_ff, dsh_ff[DW-1]};
      fits    = (trial >= {1'b0, dsor_ff});
      dsh_in  = dsh_ff;
      rem_in  = rem_ff;
      dsor_in = dsor_ff;
      quo_in  = quo_ff;
      mean_in = mean_ff;
      vok_in  = vok_ff;
      qm      = quo_ff[MW-1:0] + MW'(rem_ff != '0);
      if (cmd.divm_load) begin
         dsh_in  = {mag, {FB{1'b0}}, {(DW-UW-FB){1'b0}}};
         rem_in  = '0;
         quo_in  = '0;
         dsor_in = RW'(cnt_ff);
      end else if (cmd.divv_load) begin
         dsh_in  = {ma_acc_ff - mb_acc_ff, {FB{1'b0}}};
         rem_in  = '0;
         quo_in  = '0;
         dsor_in = dvr_ff;
         vok_in  = (cnt_ff >= CW'(2)) && (ma_acc_ff >= mb_acc_ff);
      end else if (cmd.div_step) begin
         dsh_in = {dsh_ff[DW-2:0], 1'b0};
         quo_in = {quo_ff[OW-2:0], fits};
         rem_in = fits ? RW'(trial - {1'b0, dsor_ff}) : trial[RW-1:0];
      end
      if (cmd.mean_take) begin
         mean_in = neg ? (~qm + 1'b1) : quo_ff[MW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      dsh_ff  <= dsh_in;
      rem_ff  <= rem_in;
      dsor_ff <= dsor_in;
      quo_ff  <= quo_in;
      mean_ff <= mean_in;
      vok_ff  <= vok_in;
   end

   // result register
   logic           ovld_ff, ovld_in;
   logic [127:0]   odata_ff, odata_in;
   logic [1:0]     ouser_ff, ouser_in;
   logic [VW-1:0]  var_val;
   logic           vvalid;

   assign status.out_free = !ovld_ff || rsp_tready;

   always_comb begin
      vvalid   = (cnt_ff >= CW'(2));
      var_val  = vok_ff ? quo_ff[VW-1:0] : '0;
      ovld_in  = ovld_ff && !rsp_tready;
      odata_in = odata_ff;
      ouser_in = ouser_ff;
      if (cmd.out_load) begin
         ovld_in  = 1'b1;
         odata_in = {1'b0, max_ff, min_ff, var_val, mean_ff, cnt_ff};
         ouser_in = {sat_ff, vvalid};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ovld_ff <= 1'b0;
      end else begin
         ovld_ff <= ovld_in;
      end
      odata_ff <= odata_in;
      ouser_ff <= ouser_in;
   end

   assign rsp_tvalid = ovld_ff;
   assign rsp_tdata  = odata_ff;
   assign rsp_tuser  = ouser_ff;

endmodule

`default_nettype wire

// File: hw/rtl/running_mean_variance_min_max.sv
// ----------------------------------------------------------------------------
// running_mean_variance_min_max
// Running count, floored mean and sample variance (8 fraction bits),
// minimum and maximum of a stream of signed 16-bit samples.
// ----------------------------------------------------------------------------
//
//  channel | direction | payload
//  --------+-----------+----------------------------------------------------
//  req_    | in        | tdata: sample
//  rsp_    | out       | tdata: count, mean, variance, min, max
//          |           | tuser: variance_valid, count_saturated
//
// One transaction runs update, setup, the shift-add multipliers, then the
// shared restoring divider, one quotient bit a cycle, for the mean (56 bits)
// and, after the mean is taken, the variance (104 bits), then the output load.
// One sample is in work at a time; the next is taken once the result has
// moved to the output register, so a stalled rsp_ holds only the last step.
// Synchronous active-high reset clears the sums, count, min/max and valids.
// ----------------------------------------------------------------------------
`default_nettype none

module running_mean_variance_min_max (
   input  wire           clock,
   input  wire           reset,
   input  wire           req_tvalid,
   output logic          req_tready,
   input  wire  [15:0]   req_tdata,   // [15:0] sample
   output logic          rsp_tvalid,
   input  wire           rsp_tready,
   output logic [127:0]  rsp_tdata,   // [31:0] sample_count, [55:32] mean_value,
                                      // [94:56] variance_value,
                                      // [110:95] minimum_value,
                                      // [126:111] maximum_value, [127] zero
   output logic [1:0]    rsp_tuser    // [0] variance_valid, [1] count_saturated
);

   rmv_pkg::cmd_type    cmd;
   rmv_pkg::status_type status;

   // sequencer
   rmv_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // sums, serial arithmetic and output register
   rmv_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

// File: tb/sv/running_mean_variance_min_max_tb.sv
// ----------------------------------------------------------------------------
// running_mean_variance_min_max_tb
// Self-checking bench: drives signed samples on req_, predicts count, mean,
// variance, min and max with exact integer sums, checks every rsp_ transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module running_mean_variance_min_max_tb;

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [31:0] count;
      logic [23:0] mean;
      logic [38:0] variance;
      logic        var_ok;
      logic [15:0] min_v;
      logic [15:0] max_v;
      logic        sat;
   } stats_type;

   // directed row: sample, and whether the expected result is typed in
   typedef struct {
      logic [15:0] sample;
      bit          typed;
      stats_type   result;
   } row_type;

   logic          clock;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [15:0]   req_tdata;   // [15:0] sample
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [127:0]  rsp_tdata;   // [31:0] count, [55:32] mean, [94:56] variance,
                               // [110:95] min, [126:111] max, [127] zero
   logic [1:0]    rsp_tuser;   // [0] variance_valid, [1] count_saturated

   running_mean_variance_min_max u_dut (.*);

   // predictor state
   longint unsigned  stat_count;
   logic [47:0]      stat_sum;
   logic [63:0]      stat_sumsq;
   logic signed [15:0] stat_min, stat_max;

   stats_type pending_stats[$];
   int     n_fail;
   int     send_idle_pct, recv_stall_pct;
   int     hold_cycles;
   longint cycle_count;

   function automatic stats_type predict_stats(logic signed [15:0] x);
      stats_type   r;
      logic [47:0] mag;
      logic        neg;
      logic [127:0] a, b, num;
      logic [63:0]  den;
      longint signed sm;
      if (stat_count >= 64'hFFFF_FFFF) begin
         r.sat = 1'b1;
      end else begin
         r.sat = 1'b0;
         if (stat_count == 0) begin
            stat_min = x;
            stat_max = x;
         end else begin
            if (x < stat_min) stat_min = x;
            if (x > stat_max) stat_max = x;
         end
         stat_sum   = stat_sum + {{32{x[15]}}, x};
         stat_sumsq = stat_sumsq + 64'(longint'(x) * longint'(x));
         stat_count++;
      end
      neg = stat_sum[47];
      mag = neg ? -stat_sum : stat_sum;
      r.count = stat_count[31:0];
      r.mean  = '0;
      // floor(sum*256/n) for either sign
      if (stat_count != 0) begin
         sm = longint'($signed(stat_sum)) * 256;
         if (sm >= 0) r.mean = 24'(sm / longint'(stat_count));
         else r.mean = 24'((sm - longint'(stat_count) + 1) / longint'(stat_count));
      end
      r.variance = '0;
      if (stat_count >= 2) begin
         a = 128'(stat_count) * 128'(stat_sumsq);
         b = 128'(mag) * 128'(mag);
         if (a >= b) begin
            num = (a - b) << rmv_pkg::FRAC_BITS;
            den = stat_count * (stat_count - 1);
            r.variance = 39'(num / 128'(den));
         end
      end
      r.var_ok = stat_count >= 2;
      r.min_v  = stat_min;
      r.max_v  = stat_max;
      return r;
   endfunction

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 2_000_000) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // receiver: random stalls, plus a long hold-off when asked
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready  <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // result check
   always @(posedge clock) begin
      stats_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[31:0], rsp_tdata[55:32], rsp_tdata[94:56], rsp_tuser[0],
                rsp_tdata[110:95], rsp_tdata[126:111], rsp_tuser[1]};
         if (pending_stats.size() == 0) begin
            $display("%0t: unexpected transaction %h", $time, got);
            n_fail++;
         end else begin
            want = pending_stats.pop_front();
            if (got !== want || rsp_tdata[127] !== 1'b0) begin
               $display("%0t: expected cnt %0d mean %h var %h vv %b min %h max %h sat %b",
                        $time, want.count, want.mean, want.variance, want.var_ok,
                        want.min_v, want.max_v, want.sat);
               $display("%0t: actual   cnt %0d mean %h var %h vv %b min %h max %h sat %b",
                        $time, got.count, got.mean, got.variance, got.var_ok,
                        got.min_v, got.max_v, got.sat);
               n_fail++;
            end
         end
      end
   end

   // one sample transaction; prediction made as it is accepted
   // tvalid stays high between back-to-back transactions
   task automatic send_sample(logic [15:0] s, bit typed, stats_type typed_res);
      stats_type p;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= s;
      do @(posedge clock); while (!req_tready);
      p = predict_stats(s);
      if (typed && p !== typed_res) begin
         $display("%0t: directed row %h disagrees with predictor", $time, s);
         n_fail++;
      end
      pending_stats.push_back(p);
   endtask

   row_type plan[$];

   initial begin
      int  k, phase;
      stats_type none;
      none = '0;
      reset = 1'b1;  req_tvalid = 1'b0;  req_tdata = '0;
      n_fail = 0;  cycle_count = 0;  hold_cycles = 0;
      send_idle_pct = 0;  recv_stall_pct = 0;
      stat_count = 0;  stat_sum = '0;  stat_sumsq = '0;  stat_min = 0;  stat_max = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: first sample (variance invalid), extremes, signs
      plan.push_back('{16'h8000, 1, '{32'd1, 24'h800000, 39'd0, 1'b0,
                                    16'h8000, 16'h8000, 1'b0}});
      plan.push_back('{16'h7FFF, 0, none});
      plan.push_back('{16'h0000, 0, none});
      plan.push_back('{16'hFFFF, 0, none});
      plan.push_back('{16'h0001, 0, none});
      plan.push_back('{16'h5555, 0, none});
      plan.push_back('{16'hAAAA, 0, none});
      plan.push_back('{16'h8000, 0, none});
      plan.push_back('{16'h8000, 0, none});
      plan.push_back('{16'h7FFF, 0, none});
      plan.push_back('{16'hFFFE, 0, none});
      plan.push_back('{16'h0003, 0, none});
      foreach (plan[i]) send_sample(plan[i].sample, plan[i].typed, plan[i].result);

      // random, in idling phases; one long receiver hold-off in the first
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
            default: begin send_idle_pct = 11; recv_stall_pct = 11; end
         endcase
         if (phase == 0) hold_cycles = 3000;
         for (k = 0; k < 225; k++) begin
            case ($urandom_range(3))
               0: send_sample(16'($urandom), 0, none);
               1: send_sample(16'($urandom_range(7)) ^ 16'hFFFC, 0, none);
               2: send_sample($urandom_range(1) ? 16'h7FFF : 16'h8000, 0, none);
               default: send_sample(16'($signed(10'($urandom))), 0, none);
            endcase
         end
      end
      req_tvalid <= 1'b0;

      while (pending_stats.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (n_fail == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: sim.f
hw/rtl/rmv_pkg.sv
hw/rtl/rmv_ctrl.sv
hw/rtl/rmv_dp.sv
hw/rtl/running_mean_variance_min_max.sv
tb/sv/running_mean_variance_min_max_tb.sv
